FILE: rtl/barth_jespersen_gradient_limiter_core_assert.svh
// Assertion macros used by the limiter core RTL
`ifndef BARTH_JESPERSEN_GRADIENT_LIMITER_CORE_ASSERT_SVH
`define BARTH_JESPERSEN_GRADIENT_LIMITER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BJL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// next-cycle implication, disabled in reset
`define BJL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`endif

FILE: rtl/bjl_pkg.sv
package bjl_pkg;

    localparam int FACES     = 6;
    localparam int FRAC_BITS = 16;
    localparam int PHI_BITS  = 16;
    localparam int DATA_W    = 32;

    localparam int FACE_AW   = (FACES > 1) ? $clog2(FACES) : 1;
    localparam int FACE_CW   = $clog2(FACES + 1);
    localparam int ACC_W     = 2 * DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PHI_W     = PHI_BITS + 1;
    localparam int ROOM_W    = DATA_W + 1;
    localparam int QCNT_W    = $clog2(PHI_BITS + 1);

    localparam int S_TDATA_W = 8 * DATA_W;
    localparam int M_USED_W  = PHI_W + 3 * DATA_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    localparam logic [PHI_W-1:0] PHI_ONE = {1'b1, {PHI_BITS{1'b0}}};

    typedef struct packed {
        logic              start;
        logic [ROOM_W-1:0] room;
        logic [DATA_W-1:0] step;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PHI_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/barth_jespersen_gradient_limiter_core.sv
// Sequence: a face item without tlast passes S_PROJ and S_STORE; s_tready is high again after that.
// A tlast item then scans every stored face and gives its result after S_OUTW and S_SCALE;
// each face needs a read of the delta memory and, for a nonzero delta with room left, the serial divider.
// Throughput: one item at a time; a waiting result stalls input only once the next tlast item
// has its factor ready.
// Reset: synchronous active-low aresetn clears the sequencer, face count and output valid.
`include "barth_jespersen_gradient_limiter_core_assert.svh"

module barth_jespersen_gradient_limiter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // own_value, grad_x, grad_y, grad_z, offset_x, offset_y, offset_z, neighbor_value
    input  logic [bjl_pkg::S_TDATA_W-1:0]   s_tdata,
    // neighbor_valid
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // limiter, limited_grad_x, limited_grad_y, limited_grad_z, zero fill
    output logic [bjl_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int DW = bjl_pkg::DATA_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROJ  = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUTW  = 3'd6;
    localparam logic [2:0] S_SCALE = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [bjl_pkg::FACE_CW-1:0] count_reg, count_next;
    logic [bjl_pkg::FACE_CW-1:0] idx_reg,   idx_next;
    logic [bjl_pkg::FACE_CW-1:0] idx_inc;
    logic [1:0]                  mcnt_reg,  mcnt_next;
    logic [bjl_pkg::PHI_W-1:0]   phi_reg,   phi_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    logic signed [DW-1:0] cell_reg, gx_reg, gy_reg, gz_reg, ox_reg, oy_reg, oz_reg;
    logic signed [DW-1:0] low_reg, high_reg;
    logic                 last_reg;
    logic signed [bjl_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bjl_pkg::PROD_W-1:0] prod_reg;
    logic [bjl_pkg::PHI_W-1:0] lim_reg;
    logic signed [DW-1:0] lgx_reg, lgy_reg, lgz_reg;

    logic                 s_accept;
    logic signed [DW-1:0] s_cell, s_gx, s_gy, s_gz, s_ox, s_oy, s_oz, s_nb;
    logic signed [DW-1:0] base_lo, base_hi, lo_new, hi_new;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [DW-1:0] delta_sat;
    logic signed [DW-1:0] delta;
    logic [bjl_pkg::ACC_W-bjl_pkg::FRAC_BITS-DW:0] acc_top;
    logic                 ram_we;
    logic                 face_done;
    bjl_pkg::div_req_t    div_req;
    bjl_pkg::div_rsp_t    div_rsp;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign s_cell = s_tdata[1*DW-1:0*DW];
    assign s_gx   = s_tdata[2*DW-1:1*DW];
    assign s_gy   = s_tdata[3*DW-1:2*DW];
    assign s_gz   = s_tdata[4*DW-1:3*DW];
    assign s_ox   = s_tdata[5*DW-1:4*DW];
    assign s_oy   = s_tdata[6*DW-1:5*DW];
    assign s_oz   = s_tdata[7*DW-1:6*DW];
    assign s_nb   = s_tdata[8*DW-1:7*DW];

    assign base_lo = (count_reg == '0) ? s_cell : low_reg;
    assign base_hi = (count_reg == '0) ? s_cell : high_reg;
    assign lo_new  = (s_tuser[0] && (s_nb < base_lo)) ? s_nb : base_lo;
    assign hi_new  = (s_tuser[0] && (s_nb > base_hi)) ? s_nb : base_hi;

    always_comb begin
        case (mcnt_reg)
            2'd0:    mul_a = gx_reg;
            2'd1:    mul_a = gy_reg;
            default: mul_a = gz_reg;
        endcase
        if (state_reg == S_SCALE) begin
            mul_b = DW'(phi_reg);
        end else begin
            case (mcnt_reg)
                2'd0:    mul_b = ox_reg;
                2'd1:    mul_b = oy_reg;
                default: mul_b = oz_reg;
            endcase
        end
    end

    // saturate floor(sum / 2^FRAC_BITS) to the data range
    assign acc_top = acc_reg[bjl_pkg::ACC_W-1:bjl_pkg::FRAC_BITS+DW-1];
    always_comb begin
        if ((acc_top == '0) || (acc_top == '1)) begin
            delta_sat = acc_reg[bjl_pkg::FRAC_BITS+DW-1:bjl_pkg::FRAC_BITS];
        end else if (acc_reg[bjl_pkg::ACC_W-1]) begin
            delta_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            delta_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    bjl_ram #(
        .WIDTH(DW),
        .DEPTH(bjl_pkg::FACES)
    ) u_delta_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[bjl_pkg::FACE_AW-1:0]),
        .wdata (delta_sat),
        .raddr (idx_reg[bjl_pkg::FACE_AW-1:0]),
        .rdata (delta)
    );

    bjl_ratio_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign idx_inc = idx_reg + bjl_pkg::FACE_CW'(1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        mcnt_next     = mcnt_reg;
        phi_next      = phi_reg;
        m_tvalid_next = m_tvalid_reg;
        ram_we        = 1'b0;
        face_done     = 1'b0;
        div_req       = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_PROJ;
                    mcnt_next  = 2'd0;
                end
            end
            S_PROJ: begin
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                if (count_reg < bjl_pkg::FACE_CW'(bjl_pkg::FACES)) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + bjl_pkg::FACE_CW'(1);
                end
                if (last_reg) begin
                    state_next = S_READ;
                    idx_next   = '0;
                    phi_next   = bjl_pkg::PHI_ONE;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (delta > 0) begin
                    if (high_reg > cell_reg) begin
                        div_req.start = 1'b1;
                        div_req.room  = bjl_pkg::ROOM_W'({high_reg[DW-1], high_reg}
                                        - {cell_reg[DW-1], cell_reg});
                        div_req.step  = delta;
                        state_next    = S_DIV;
                    end else begin
                        phi_next  = '0;
                        face_done = 1'b1;
                    end
                end else if (delta < 0) begin
                    if (low_reg < cell_reg) begin
                        div_req.start = 1'b1;
                        div_req.room  = bjl_pkg::ROOM_W'({cell_reg[DW-1], cell_reg}
                                        - {low_reg[DW-1], low_reg});
                        div_req.step  = DW'(-{delta[DW-1], delta});
                        state_next    = S_DIV;
                    end else begin
                        phi_next  = '0;
                        face_done = 1'b1;
                    end
                end else begin
                    face_done = 1'b1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot < phi_reg) begin
                        phi_next = div_rsp.quot;
                    end
                    face_done = 1'b1;
                end
            end
            S_OUTW: begin
                if (!m_tvalid_reg) begin
                    state_next = S_SCALE;
                    mcnt_next  = 2'd0;
                end
            end
            S_SCALE: begin
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (face_done) begin
            if (idx_inc == count_reg) begin
                state_next = S_OUTW;
                count_next = '0;
            end else begin
                idx_next   = idx_inc;
                state_next = S_READ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            mcnt_reg     <= '0;
            phi_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            mcnt_reg     <= mcnt_next;
            phi_reg      <= phi_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (s_accept) begin
            cell_reg <= s_cell;
            gx_reg   <= s_gx;
            gy_reg   <= s_gy;
            gz_reg   <= s_gz;
            ox_reg   <= s_ox;
            oy_reg   <= s_oy;
            oz_reg   <= s_oz;
            last_reg <= s_tlast;
            low_reg  <= lo_new;
            high_reg <= hi_new;
            acc_reg  <= '0;
        end else if ((state_reg == S_PROJ) && (mcnt_reg != 2'd0)) begin
            acc_reg <= acc_reg + {prod_reg[bjl_pkg::PROD_W-1], prod_reg};
        end
        if (state_reg == S_SCALE) begin
            lim_reg <= phi_reg;
            case (mcnt_reg)
                2'd1:    lgx_reg <= prod_reg[bjl_pkg::PHI_BITS+DW-1:bjl_pkg::PHI_BITS];
                2'd2:    lgy_reg <= prod_reg[bjl_pkg::PHI_BITS+DW-1:bjl_pkg::PHI_BITS];
                2'd3:    lgz_reg <= prod_reg[bjl_pkg::PHI_BITS+DW-1:bjl_pkg::PHI_BITS];
                default: lgx_reg <= lgx_reg;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(bjl_pkg::M_TDATA_W-bjl_pkg::M_USED_W){1'b0}},
                       lgz_reg, lgy_reg, lgx_reg, lim_reg};

    `BJL_ASSERT_IMP(a_phi_range, aclk, aresetn, 1'b1, phi_reg <= bjl_pkg::PHI_ONE)
    `BJL_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1,
        count_reg <= bjl_pkg::FACE_CW'(bjl_pkg::FACES))
    `BJL_ASSERT_IMP(a_div_alive, aclk, aresetn, state_reg == S_DIV,
        div_rsp.busy || div_rsp.done)
    `BJL_ASSERT_NXT(a_accept_proj, aclk, aresetn, s_accept, state_reg == S_PROJ)
    `BJL_ASSERT_IMP(a_scan_bound, aclk, aresetn,
        (state_reg == S_READ) || (state_reg == S_EVAL), idx_reg < count_reg)

endmodule

FILE: rtl/bjl_ram.sv
module bjl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bjl_ratio_div.sv
module bjl_ratio_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bjl_pkg::div_req_t req,
    output bjl_pkg::div_rsp_t rsp
);

    logic [bjl_pkg::ROOM_W-1:0] rem_reg,  rem_next;
    logic [bjl_pkg::DATA_W-1:0] step_reg, step_next;
    logic [bjl_pkg::PHI_W-1:0]  quot_reg, quot_next;
    logic [bjl_pkg::QCNT_W-1:0] cnt_reg,  cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [bjl_pkg::ROOM_W-1:0] trial;
    logic                       fits;

    assign trial = {rem_reg[bjl_pkg::ROOM_W-2:0], 1'b0};
    assign fits  = trial >= {1'b0, step_reg};

    always_comb begin
        rem_next  = rem_reg;
        step_next = step_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            step_next = req.step;
            if (req.room >= {1'b0, req.step}) begin
                quot_next = bjl_pkg::PHI_ONE;
                done_next = 1'b1;
            end else begin
                rem_next  = req.room;
                quot_next = '0;
                cnt_next  = bjl_pkg::QCNT_W'(bjl_pkg::PHI_BITS);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next  = fits ? (trial - {1'b0, step_reg}) : trial;
            quot_next = {quot_reg[bjl_pkg::PHI_W-2:0], fits};
            cnt_next  = cnt_reg - bjl_pkg::QCNT_W'(1);
            if (cnt_reg == bjl_pkg::QCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        step_reg <= step_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
